FILE: rtl/tpsr_pkg.sv
package tpsr_pkg;

  localparam int unsigned RATE_W    = 17;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CYC_W     = 24;
  localparam int unsigned RUN_W     = 20;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CLK_W     = 20;
  localparam int unsigned DIV_SHIFT = 5;
  localparam int unsigned LO_W      = CYC_W + RATE_W - DIV_SHIFT;
  localparam int unsigned HI_W      = 37;
  localparam int unsigned ACC_W     = HI_W + LO_W;
  localparam int unsigned ADD_W     = HI_W + 1;
  localparam int unsigned RECIP_S   = LO_W + 15;
  localparam int unsigned QUOT_W    = ACC_W - RECIP_S;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CLK_W-1:0]   CYCLE_CLOCK = 20'd985248;
  localparam logic [CYC_W-1:0]   FIXED_PAUSE = 24'd20400;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 8'h10;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH  = 8'hF0;
  localparam logic [RUN_W-1:0]   RUN_MAX     = 20'hFFFFF;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 17'd30303;

  // odd part of the cycle clock and its rounded-up reciprocal
  localparam logic [63:0]     CLK_ODD    = 64'(CYCLE_CLOCK >> DIV_SHIFT);
  localparam logic [63:0]     RECIP_WIDE = ((64'd1 << RECIP_S) + CLK_ODD - 64'd1) / CLK_ODD;
  localparam logic [HI_W-1:0] RECIP      = RECIP_WIDE[HI_W-1:0];

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH  = 2'd2;

  typedef logic [RUN_W-1:0] run_t;

  function automatic run_t sat_run(input logic [QUOT_W-1:0] n);
    run_t r;
    r = (n[QUOT_W-1:RUN_W] != '0) ? RUN_MAX : n[RUN_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/tape_pulse_to_sample_runs.sv
// Converts tape-image bytes into pairs of constant-level runs. A pulse byte or a fixed
// pause is taken, then a shared 38-bit adder does 17 shift-add multiply steps
// (cycles * sample_rate) and 36 shift-add steps multiplying that product, less its five
// low bits, by a fixed reciprocal of 985248 / 32; the two runs are then offered one per
// cycle while out_ready is high. The block takes no new byte until the second run of a
// pulse has been taken. Length bytes of a three-byte pause other than the last are
// absorbed with no result. Configuration writes are taken in any cycle and must only
// come while idle.
module tape_pulse_to_sample_runs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tpsr_pkg::BYTE_W-1:0]     in_tap_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tpsr_pkg::LEVEL_W-1:0]    out_sample_value,
  output logic [tpsr_pkg::RUN_W-1:0]      out_run_length,
  output logic                            out_last_of_pulse,
  input  logic                            cfg_we,
  input  logic [tpsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpsr_pkg::RATE_W-1:0]     cfg_wdata
);
  import tpsr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_RECIP = 3'd2;
  localparam logic [2:0] ST_OUT1  = 3'd3;
  localparam logic [2:0] ST_OUT2  = 3'd4;

  localparam logic [5:0]  MUL_LAST   = 6'(RATE_W - 1);
  localparam logic [5:0]  RECIP_LAST = 6'(LO_W - 1);
  localparam int unsigned X_LSB      = LO_W - RATE_W + DIV_SHIFT;

  logic [2:0]        state_r, state_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CYC_W-1:0]  cycles_r, cycles_nxt;
  logic [1:0]        pause_left_r, pause_left_nxt;
  logic [RATE_W-1:0] rate_r;
  logic              version_r;
  logic              level_high_r;

  logic [HI_W-1:0]   opb;
  logic [ADD_W-1:0]  sum;
  logic [ACC_W-1:0]  shifted;

  logic              in_fire, out_fire;
  logic [CYC_W-1:0]  pause_acc;
  logic [QUOT_W-1:0] len, second_len;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // shared adder: upper half plus multiplicand, then shift right
  always_comb begin
    opb = '0;
    if (acc_r[0]) begin
      opb = (state_r == ST_RECIP) ? RECIP : {{(HI_W-CYC_W){1'b0}}, cycles_r};
    end
    sum = {1'b0, acc_r[ACC_W-1:LO_W]} + {1'b0, opb};
  end

  assign shifted = {sum, acc_r[LO_W-1:1]};

  always_comb begin
    unique case (pause_left_r)
      2'd3:    pause_acc = cycles_r | {16'b0, in_tap_byte};
      2'd2:    pause_acc = cycles_r | {8'b0, in_tap_byte, 8'b0};
      default: pause_acc = cycles_r | {in_tap_byte, 16'b0};
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    cycles_nxt     = cycles_r;
    pause_left_nxt = pause_left_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt = {{(ACC_W-RATE_W){1'b0}}, rate_r};
          cnt_nxt = '0;
          if (pause_left_r != 2'd0) begin
            cycles_nxt     = pause_acc;
            pause_left_nxt = pause_left_r - 2'd1;
            if (pause_left_r == 2'd1) begin
              state_nxt = ST_MUL;
            end
          end else if (in_tap_byte != '0) begin
            cycles_nxt = {13'b0, in_tap_byte, 3'b0};
            state_nxt  = ST_MUL;
          end else if (!version_r) begin
            cycles_nxt = FIXED_PAUSE;
            state_nxt  = ST_MUL;
          end else begin
            cycles_nxt     = '0;
            pause_left_nxt = 2'd3;
          end
        end
      end
      ST_MUL: begin
        acc_nxt = shifted;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == MUL_LAST) begin
          // product drops its five low bits (the divisor's factor of 32) and becomes the next multiplier
          acc_nxt   = {{HI_W{1'b0}}, shifted[X_LSB +: LO_W]};
          cnt_nxt   = '0;
          state_nxt = ST_RECIP;
        end
      end
      ST_RECIP: begin
        acc_nxt = shifted;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == RECIP_LAST) begin
          state_nxt = ST_OUT1;
        end
      end
      ST_OUT1: begin
        if (out_fire) state_nxt = ST_OUT2;
      end
      ST_OUT2: begin
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      pause_left_r <= '0;
      cycles_r     <= '0;
      rate_r       <= RATE_RESET;
      version_r    <= 1'b0;
      level_high_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pause_left_r <= pause_left_nxt;
      cycles_r     <= cycles_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_SAMPLE_RATE) rate_r <= cfg_wdata;
        if (cfg_index == CFG_TAP_VERSION) version_r <= cfg_wdata[0];
        if (cfg_index == CFG_START_HIGH) level_high_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign len        = acc_r[ACC_W-1:RECIP_S];
  assign second_len = {1'b0, len[QUOT_W-1:1]} + {{(QUOT_W-1){1'b0}}, len[0]};

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = (state_r == ST_OUT1) || (state_r == ST_OUT2);
  assign out_last_of_pulse = (state_r == ST_OUT2);
  assign out_sample_value  = (level_high_r ^ out_last_of_pulse) ? LEVEL_HIGH : LEVEL_LOW;
  assign out_run_length    = out_last_of_pulse ? sat_run(second_len)
                                               : sat_run({1'b0, len[QUOT_W-1:1]});

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a run is pending");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last_of_pulse) |=> (out_valid && out_last_of_pulse))
    else $error("second run of pulse missing");

  a_idle_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_of_pulse) |=> in_ready)
    else $error("not ready after run pair");

  a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pause_left_r == 2'd0 && in_tap_byte != '0) |=> (!in_ready && !out_valid))
    else $error("pulse byte did not start computation");

endmodule

FILE: bench/tpsr_checker.sv
module tpsr_checker
  import tpsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_tap_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [LEVEL_W-1:0]   out_sample_value,
  input  logic [RUN_W-1:0]     out_run_length,
  input  logic                 out_last_of_pulse,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    run_t               run_len;
    logic               last_run;
  } level_run_t;

  level_run_t          level_runs[$];
  logic [RATE_W-1:0]   rate = RATE_RESET;
  logic                three_byte_pause = 1'b0;
  logic                level_high = 1'b0;
  logic [1:0]          len_bytes_left = 2'd0;
  logic [CYC_W-1:0]    pause_len = '0;
  int                  reported = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic run_t clip_run(input longint unsigned n);
    return (n > longint'(RUN_MAX)) ? RUN_MAX : run_t'(n);
  endfunction

  task automatic queue_pulse(input logic [CYC_W-1:0] cycles);
    longint unsigned samples;
    level_run_t r;
    samples = (longint'(cycles) * longint'(rate)) / longint'(CYCLE_CLOCK);
    r.level = level_high ? LEVEL_HIGH : LEVEL_LOW;
    r.run_len = clip_run(samples / 2);
    r.last_run = 1'b0;
    level_runs.push_back(r);
    level_high = ~level_high;
    r.level = level_high ? LEVEL_HIGH : LEVEL_LOW;
    r.run_len = clip_run(samples / 2 + samples % 2);
    r.last_run = 1'b1;
    level_runs.push_back(r);
    level_high = ~level_high;
  endtask

  task automatic take_byte(input logic [BYTE_W-1:0] b);
    if (len_bytes_left != 2'd0) begin
      // length bytes arrive low byte first
      pause_len = pause_len | (CYC_W'(b) << (8 * (3 - len_bytes_left)));
      len_bytes_left = len_bytes_left - 2'd1;
      if (len_bytes_left == 2'd0) queue_pulse(pause_len);
    end else if (b != '0) begin
      queue_pulse(CYC_W'({b, 3'b000}));
    end else if (!three_byte_pause) begin
      queue_pulse(FIXED_PAUSE);
    end else begin
      len_bytes_left = 2'd3;
      pause_len = '0;
    end
  endtask

  task automatic check_run();
    level_run_t want;
    if (level_runs.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        $display("unexpected run: level %0h len %0d last %0b", out_sample_value,
                 out_run_length, out_last_of_pulse);
        reported++;
      end
    end else begin
      want = level_runs.pop_front();
      if (want.level !== out_sample_value || want.run_len !== out_run_length ||
          want.last_run !== out_last_of_pulse) begin
        fail_count++;
        if (reported < 10) begin
          $display("run mismatch: expected level %0h len %0d last %0b, got %0h %0d %0b",
                   want.level, want.run_len, want.last_run, out_sample_value,
                   out_run_length, out_last_of_pulse);
          reported++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rate = RATE_RESET;
      three_byte_pause = 1'b0;
      level_high = 1'b0;
      len_bytes_left = 2'd0;
      pause_len = '0;
      level_runs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: rate = cfg_wdata;
          CFG_TAP_VERSION: three_byte_pause = cfg_wdata[0];
          CFG_START_HIGH:  level_high = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_byte(in_tap_byte);
      if (out_valid && out_ready) check_run();
    end
    pending = level_runs.size();
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import tpsr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int PHASES           = 10;
  localparam int PHASE_ITEMS      = 195;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_tap_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LEVEL_W-1:0]   out_sample_value;
  logic [RUN_W-1:0]     out_run_length;
  logic                 out_last_of_pulse;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]    cfg_wdata = '0;

  int fail_count;
  int pending;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;
  bit three_byte_mode = 1'b0;

  tape_pulse_to_sample_runs i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tap_byte      (in_tap_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_run_length   (out_run_length),
    .out_last_of_pulse(out_last_of_pulse),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  tpsr_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tap_byte      (in_tap_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_run_length   (out_run_length),
    .out_last_of_pulse(out_last_of_pulse),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #60000000;
    $display("simulation failed");
    $finish;
  end

  // receiver: ready bursts, random stalls and one long hold-off
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tap_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pause(input logic [CYC_W-1:0] cycles);
    send_byte(8'h00);
    send_byte(cycles[7:0]);
    send_byte(cycles[15:8]);
    send_byte(cycles[23:16]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [RATE_W-1:0] rate, input logic ver,
                           input logic hi);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_TAP_VERSION, RATE_W'(ver));
    write_reg(CFG_START_HIGH, RATE_W'(hi));
    write_reg(CFG_UNUSED, RATE_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    three_byte_mode = ver;
  endtask

  task automatic random_phase(input int n);
    int count;
    int pick;
    logic [CYC_W-1:0] plen;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(0, 9);
      if (three_byte_mode && pick < 2) begin
        plen = ($urandom_range(0, 3) == 0) ? CYC_W'($urandom) : CYC_W'($urandom_range(0, 40000));
        send_pause(plen);
        count += 4;
      end else if (pick == 2 && (!three_byte_mode || $urandom_range(0, 3) == 0)) begin
        // lone zero: fixed pause, or a pause whose length takes the next bytes
        send_byte(8'h00);
        count++;
      end else begin
        send_byte(BYTE_W'($urandom_range(1, 255)));
        count++;
      end
    end
  endtask

  initial begin
    logic [RATE_W-1:0] rate;
    int pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hAA);
    settle();

    configure(17'd96000, 1'b1, 1'b1);
    send_pause(24'hFFFFFF);
    send_pause(24'h000000);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'h01);
    settle();
    // version drops to fixed pause while a length is half read
    write_reg(CFG_TAP_VERSION, RATE_W'(0));
    cfg_we <= 1'b0;
    @(posedge clk);
    three_byte_mode = 1'b0;
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    settle();

    configure(17'h1FFFF, 1'b1, 1'b0);
    send_pause(24'hFFFFFF);
    settle();
    configure(17'd0, 1'b0, 1'b1);
    send_byte(8'h40);
    send_byte(8'h00);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) idle_on = 1'b0;
      if (phase == 0) begin
        configure(17'd4000, 1'b1, 1'b0);
      end else if (phase == 1) begin
        configure(17'd96000, 1'b0, 1'b1);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) rate = 17'd4000;
        else if (pick == 1) rate = 17'd96000;
        else if (pick == 2) rate = RATE_W'($urandom);
        else rate = RATE_W'($urandom_range(4000, 96000));
        configure(rate, 1'($urandom), 1'($urandom));
      end
      if (phase == 2) long_hold = 1'b1;
      random_phase(PHASE_ITEMS);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
